FILE: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// shared constants, codes and controller/datapath structs of the console
// line editor
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int LINE_CAP_DEFAULT = 32;
   localparam int CODE_W           = 8;
   localparam int CSR_INDEX_W      = 2;

   localparam logic [CODE_W-1:0] CH_BS  = 8'h08;
   localparam logic [CODE_W-1:0] CH_TAB = 8'h09;
   localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CODE_W-1:0] CH_SP  = 8'h20;

   localparam logic [CODE_W-1:0] ESCAPE_RESET  = 8'd27;
   localparam logic [CODE_W-1:0] BRACKET_RESET = 8'd91;
   localparam logic [CODE_W-1:0] RECALL_RESET  = 8'd65;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ESCAPE  = 2'd0,
      CSR_BRACKET = 2'd1,
      CSR_RECALL  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      SEL_CHAR,
      SEL_LF,
      SEL_CR,
      SEL_BS,
      SEL_SP,
      SEL_MEM
   } out_sel_type;

   typedef enum logic {
      RUN_RECALL,
      RUN_DELIVER
   } run_mode_type;

   typedef struct packed {
      logic         load_char;
      logic         set_escape;
      logic         set_bracket;
      logic         clear_flags;
      logic         push;
      out_sel_type  sel;
      logic         last;
      logic         store_char;
      logic         shorten;
      logic         start_run;
      run_mode_type mode;
      logic         step;
      logic         finish_run;
      logic         clear_history;
   } cmd_type;

   typedef struct packed {
      logic is_escape;
      logic is_bracket;
      logic is_recall;
      logic is_lf;
      logic is_bs;
      logic is_cr_tab;
      logic escape_seen;
      logic bracket_seen;
      logic line_empty;
      logic line_full;
      logic history_empty;
      logic out_free;
      logic run_last;
   } status_type;

endpackage

FILE: hdl/cle_req_if.sv
// ----------------------------------------------------------------------------
// cle_req_if
// received byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       reader_ready;

   modport source (output valid, output rx_byte, output reader_ready, input ready);
   modport sink   (input valid, input rx_byte, input reader_ready, output ready);
endinterface

FILE: hdl/cle_rsp_if.sv
// ----------------------------------------------------------------------------
// cle_rsp_if
// echo and line byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       kind;
   logic       last;

   modport source (output valid, output out_byte, output kind, output last, input ready);
   modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

FILE: hdl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// code registers, line/history memory with bank swap, lengths, escape flags
// and the output register
// ----------------------------------------------------------------------------
module cle_datapath #(
   parameter int LINE_CAP = cle_pkg::LINE_CAP_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [cle_pkg::CODE_W-1:0]         rx_byte,
   input  logic                               csr_we,
   input  logic [cle_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cle_pkg::CODE_W-1:0]         csr_wdata,
   input  cle_pkg::cmd_type                   cmd,
   output cle_pkg::status_type                status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cle_pkg::CODE_W-1:0]         out_byte,
   output logic                               kind,
   output logic                               last
);
   import cle_pkg::*;

   localparam int IDX_W  = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
   localparam int LEN_W  = $clog2(LINE_CAP + 1);
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   logic [CODE_W-1:0] escape_code_ff, bracket_code_ff, recall_code_ff;
   logic [CODE_W-1:0] char_ff;
   logic              escape_seen_ff, bracket_seen_ff;
   logic [LEN_W-1:0]  line_len_ff, line_len_in;
   logic [LEN_W-1:0]  hist_len_ff, hist_len_in;
   logic              line_bank_ff;
   run_mode_type      mode_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CODE_W-1:0] rd_data_ff;
   logic [CODE_W-1:0] mem [DEPTH];

   logic              rsp_valid_ff;
   logic [CODE_W-1:0] out_byte_ff, out_byte_in;
   logic              kind_ff, last_ff;

   run_mode_type      rd_mode;
   logic              rd_en, wr_en;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [IDX_W-1:0]  rd_idx, wr_idx;
   logic [CODE_W-1:0] wr_data;
   logic [LEN_W-1:0]  run_len;
   logic              out_free;

   // status
   assign run_len  = (mode_ff == RUN_RECALL) ? hist_len_ff : line_len_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.is_escape     = char_ff == escape_code_ff;
      status.is_bracket    = char_ff == bracket_code_ff;
      status.is_recall     = char_ff == recall_code_ff;
      status.is_lf         = char_ff == CH_LF;
      status.is_bs         = char_ff == CH_BS;
      status.is_cr_tab     = (char_ff == CH_CR) || (char_ff == CH_TAB);
      status.escape_seen   = escape_seen_ff;
      status.bracket_seen  = bracket_seen_ff;
      status.line_empty    = line_len_ff == '0;
      status.line_full     = line_len_ff == LEN_W'(LINE_CAP);
      status.history_empty = hist_len_ff == '0;
      status.out_free      = out_free;
      status.run_last      = (LEN_W'(idx_ff) + LEN_W'(1)) == run_len;
   end

   // memory addressing: bank bit over entry index
   always_comb begin
      rd_mode = cmd.start_run ? cmd.mode : mode_ff;
      rd_idx  = cmd.start_run ? '0 : idx_ff + IDX_W'(1);
      rd_addr = {(rd_mode == RUN_RECALL) ? ~line_bank_ff : line_bank_ff, rd_idx};
      rd_en   = cmd.start_run || cmd.step;
      wr_en   = cmd.store_char || (cmd.step && (mode_ff == RUN_RECALL));
      wr_idx  = cmd.store_char ? line_len_ff[IDX_W-1:0] : idx_ff;
      wr_data = cmd.store_char ? char_ff : rd_data_ff;
      wr_addr = {line_bank_ff, wr_idx};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // lengths
   always_comb begin
      line_len_in = line_len_ff;
      hist_len_in = hist_len_ff;
      if (cmd.store_char) begin
         line_len_in = line_len_ff + LEN_W'(1);
      end else if (cmd.shorten) begin
         line_len_in = line_len_ff - LEN_W'(1);
      end else if (cmd.finish_run && (mode_ff == RUN_RECALL)) begin
         line_len_in = hist_len_ff;
      end else if (cmd.finish_run) begin
         line_len_in = '0;
         hist_len_in = line_len_ff;
      end
      if (cmd.clear_history) begin
         hist_len_in = '0;
      end
   end

   // output byte select
   always_comb begin
      unique case (cmd.sel)
         SEL_CHAR: out_byte_in = char_ff;
         SEL_LF:   out_byte_in = CH_LF;
         SEL_CR:   out_byte_in = CH_CR;
         SEL_BS:   out_byte_in = CH_BS;
         SEL_SP:   out_byte_in = CH_SP;
         SEL_MEM:  out_byte_in = rd_data_ff;
         default:  out_byte_in = char_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_code_ff  <= ESCAPE_RESET;
         bracket_code_ff <= BRACKET_RESET;
         recall_code_ff  <= RECALL_RESET;
         escape_seen_ff  <= 1'b0;
         bracket_seen_ff <= 1'b0;
         line_len_ff     <= '0;
         hist_len_ff     <= '0;
         line_bank_ff    <= 1'b0;
         mode_ff         <= RUN_DELIVER;
         idx_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ESCAPE:  escape_code_ff  <= csr_wdata;
               CSR_BRACKET: bracket_code_ff <= csr_wdata;
               CSR_RECALL:  recall_code_ff  <= csr_wdata;
               default:     ;
            endcase
         end
         if (cmd.set_escape) begin
            escape_seen_ff <= 1'b1;
         end else if (cmd.clear_flags) begin
            escape_seen_ff <= 1'b0;
         end
         if (cmd.set_bracket) begin
            bracket_seen_ff <= 1'b1;
         end else if (cmd.clear_flags) begin
            bracket_seen_ff <= 1'b0;
         end
         line_len_ff <= line_len_in;
         hist_len_ff <= hist_len_in;
         if (cmd.finish_run && (mode_ff == RUN_DELIVER)) begin
            line_bank_ff <= ~line_bank_ff;
         end
         if (cmd.start_run) begin
            mode_ff <= cmd.mode;
            idx_ff  <= '0;
         end else if (cmd.step) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= rx_byte;
      end
      if (cmd.push) begin
         out_byte_ff <= out_byte_in;
         kind_ff     <= (cmd.sel == SEL_MEM) && (mode_ff == RUN_DELIVER);
         last_ff     <= cmd.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_byte  = out_byte_ff;
   assign kind      = kind_ff;
   assign last      = last_ff;

   a_line_len_bound : assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LEN_W'(LINE_CAP))
      else $error("line length beyond capacity");

   a_hist_len_bound : assert property (@(posedge clock) disable iff (reset)
      hist_len_ff <= LEN_W'(LINE_CAP))
      else $error("history length beyond capacity");

   a_step_in_run : assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (LEN_W'(idx_ff) < run_len))
      else $error("run index past run length");

endmodule

FILE: hdl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// per-byte sequencer: classifies the byte, drives echo transfers and the
// recall and delivery runs over the line memory
// ----------------------------------------------------------------------------
module cle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                reader_ready,
   output logic                req_ready,
   input  cle_pkg::status_type status,
   output cle_pkg::cmd_type    cmd
);
   import cle_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_CHAR,
      S_BS1,
      S_SP,
      S_BS2,
      S_LF,
      S_CR,
      S_EM
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      goto_deliver;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      goto_deliver = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready && reader_ready) begin
               cmd.load_char = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            priority if (status.is_escape) begin
               cmd.set_escape = 1'b1;
               goto_deliver   = status.is_lf;
            end else if (status.escape_seen && status.bracket_seen) begin
               cmd.clear_flags = 1'b1;
               if (status.is_recall && !status.is_lf && !status.history_empty) begin
                  cmd.start_run = 1'b1;
                  cmd.mode      = RUN_RECALL;
                  state_in      = S_EM;
               end else begin
                  goto_deliver = status.is_lf;
               end
            end else if (status.escape_seen) begin
               cmd.set_bracket = status.is_bracket;
               goto_deliver    = status.is_lf;
            end else if (status.is_lf) begin
               state_in = S_LF;
            end else if (status.is_bs) begin
               state_in = status.line_empty ? S_IDLE : S_BS1;
            end else if (status.is_cr_tab) begin
               state_in = S_IDLE;
            end else begin
               state_in = status.line_full ? S_IDLE : S_CHAR;
            end
            if (goto_deliver) begin
               if (status.line_empty) begin
                  cmd.clear_history = 1'b1;
               end else begin
                  cmd.start_run = 1'b1;
                  cmd.mode      = RUN_DELIVER;
                  state_in      = S_EM;
               end
            end
         end
         S_CHAR: begin
            if (status.out_free) begin
               cmd.push       = 1'b1;
               cmd.sel        = SEL_CHAR;
               cmd.last       = 1'b1;
               cmd.store_char = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_BS1: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_BS;
               state_in = S_SP;
            end
         end
         S_SP: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_SP;
               state_in = S_BS2;
            end
         end
         S_BS2: begin
            if (status.out_free) begin
               cmd.push    = 1'b1;
               cmd.sel     = SEL_BS;
               cmd.last    = 1'b1;
               cmd.shorten = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_LF: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_LF;
               state_in = S_CR;
            end
         end
         S_CR: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_CR;
               cmd.last = status.line_empty;
               if (status.line_empty) begin
                  cmd.clear_history = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  cmd.start_run = 1'b1;
                  cmd.mode      = RUN_DELIVER;
                  state_in      = S_EM;
               end
            end
         end
         S_EM: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               cmd.sel  = SEL_MEM;
               cmd.last = status.run_last;
               cmd.step = 1'b1;
               if (status.run_last) begin
                  cmd.finish_run = 1'b1;
                  state_in       = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      req_ready_in = state_in == S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff && (state_ff == S_IDLE);

   a_push_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> status.out_free)
      else $error("transfer pushed into a full output register");

   a_drop_stays_idle : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !reader_ready) |=> (state_ff == S_IDLE))
      else $error("dropped byte started processing");

   a_run_holds : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EM && !status.out_free) |=> (state_ff == S_EM))
      else $error("run left while output stalled");

endmodule

FILE: hdl/console_line_editor.sv
// throughput: a new byte is taken only once the results of the previous one are
// pushed; runs from the line memory port give one result per cycle while the
// output register is not stalled
// reset: synchronous, codes back to 27/91/65, line and history empty,
// escape state cleared; no memory clearing pass
// ----------------------------------------------------------------------------
// console_line_editor
// console line editor: line buffer with echo, backspace, one-line history
// recall by escape sequence and line delivery on newline
// ----------------------------------------------------------------------------
module console_line_editor #(
   parameter int LINE_CAP = cle_pkg::LINE_CAP_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cle_req_if.sink                         req_chan,
   cle_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [cle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cle_pkg::CODE_W-1:0]      csr_wdata
);
   import cle_pkg::*;

   cmd_type    cmd;
   status_type status;

   cle_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .reader_ready (req_chan.reader_ready),
      .req_ready    (req_chan.ready),
      .status       (status),
      .cmd          (cmd)
   );

   cle_datapath #(
      .LINE_CAP (LINE_CAP)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_chan.rx_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .kind      (rsp_chan.kind),
      .last      (rsp_chan.last)
   );

endmodule

FILE: dv/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// watches the byte, result and register ports of the console line editor,
// predicts the echo and line bytes of every accepted byte and compares each
// result transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
module cle_checker #(
   parameter int LINE_CAP = cle_pkg::LINE_CAP_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   cle_req_if                              req_chan,
   cle_rsp_if                              rsp_chan,
   input  logic                            csr_we,
   input  logic [cle_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cle_pkg::CODE_W-1:0]      csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;

   localparam logic KIND_ECHO = 1'b0;
   localparam logic KIND_LINE = 1'b1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic       last;
   } console_out_t;

   console_out_t console_out_q[$];

   logic [7:0] escape_code;
   logic [7:0] bracket_code;
   logic [7:0] recall_code;
   logic [7:0] line_buf[LINE_CAP];
   logic [7:0] history_buf[LINE_CAP];
   int         line_len;
   int         history_len;
   logic       escape_seen;
   logic       bracket_seen;
   int         mismatch_count = 0;
   int         outstanding = 0;

   assign fail_count = mismatch_count;
   assign pending    = outstanding;

   function automatic console_out_t make_out(logic [7:0] b, logic k);
      make_out = '{out_byte: b, kind: k, last: 1'b0};
   endfunction

   function automatic void edit_line(logic [7:0] ch);
      console_out_t run_q[$];
      int           i;
      if (ch == escape_code) begin
         escape_seen = 1'b1;
      end else if (escape_seen) begin
         if (bracket_seen) begin
            if (ch == recall_code && ch != CH_LF && history_len > 0) begin
               for (i = 0; i < history_len; i++) begin
                  run_q.push_back(make_out(history_buf[i], KIND_ECHO));
                  line_buf[i] = history_buf[i];
               end
               line_len = history_len;
            end
            escape_seen  = 1'b0;
            bracket_seen = 1'b0;
         end else if (ch == bracket_code) begin
            bracket_seen = 1'b1;
         end
      end else if (ch == CH_LF) begin
         run_q.push_back(make_out(CH_LF, KIND_ECHO));
         run_q.push_back(make_out(CH_CR, KIND_ECHO));
      end else if (ch == CH_BS) begin
         if (line_len > 0) begin
            run_q.push_back(make_out(CH_BS, KIND_ECHO));
            run_q.push_back(make_out(CH_SP, KIND_ECHO));
            run_q.push_back(make_out(CH_BS, KIND_ECHO));
            line_len--;
         end
      end else if (ch == CH_CR || ch == CH_TAB) begin
      end else if (line_len < LINE_CAP) begin
         run_q.push_back(make_out(ch, KIND_ECHO));
         line_buf[line_len] = ch;
         line_len++;
      end

      // newline delivers the line in every state
      if (ch == CH_LF) begin
         for (i = 0; i < line_len; i++) begin
            run_q.push_back(make_out(line_buf[i], KIND_LINE));
            history_buf[i] = line_buf[i];
         end
         history_len = line_len;
         line_len    = 0;
      end

      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      for (i = 0; i < run_q.size(); i++) console_out_q.push_back(run_q[i]);
   endfunction

   always @(posedge clock) begin
      console_out_t got;
      console_out_t want;
      if (reset) begin
         escape_code  = ESCAPE_RESET;
         bracket_code = BRACKET_RESET;
         recall_code  = RECALL_RESET;
         line_len     = 0;
         history_len  = 0;
         escape_seen  = 1'b0;
         bracket_seen = 1'b0;
         console_out_q.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{out_byte: rsp_chan.out_byte, kind: rsp_chan.kind, last: rsp_chan.last};
            if (console_out_q.size() == 0) begin
               $error("unexpected transfer: out_byte %0h kind %0b last %0b",
                      got.out_byte, got.kind, got.last);
               mismatch_count++;
            end else begin
               want = console_out_q.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %0h, actual %0h",
                         want.out_byte, got.out_byte);
                  mismatch_count++;
               end
               if (got.kind !== want.kind) begin
                  $error("kind mismatch: expected %0b, actual %0b", want.kind, got.kind);
                  mismatch_count++;
               end
               if (got.last !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ESCAPE:  escape_code  = csr_wdata;
               CSR_BRACKET: bracket_code = csr_wdata;
               CSR_RECALL:  recall_code  = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready && req_chan.reader_ready)
            edit_line(req_chan.rx_byte);
      end
      outstanding = console_out_q.size();
   end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the console line editor: directed bytes for echo, backspace,
// ignored controls, absent reader, escape recall and line delivery, then
// random typed lines, recalls and noise under several escape code settings,
// with random gaps on both channels; results are checked by cle_checker
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;

   localparam int LINE_CAP = LINE_CAP_DEFAULT;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CODE_W-1:0]      csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     items_sent;
   logic                   calm;
   logic [7:0]             escape_code;
   logic [7:0]             bracket_code;
   logic [7:0]             recall_code;

   cle_req_if req_chan();
   cle_rsp_if rsp_chan();

   console_line_editor #(.LINE_CAP(LINE_CAP)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cle_checker #(.LINE_CAP(LINE_CAP)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 26);
      end
   end

   function automatic logic sender_idles();
      return !calm && ($urandom_range(99) < 26);
   endfunction

   function automatic logic [7:0] typed_byte();
      int r;
      r = $urandom_range(9);
      if (r == 0) return CH_BS;
      if (r == 1) return 8'($urandom_range(255));
      return 8'($urandom_range(126, 32));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic present = 1'b1);
      @(negedge clock);
      while (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.rx_byte      <= b;
      req_chan.reader_ready <= present;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (present) items_sent++;
   endtask

   // wait for every predicted result, then for a run that may still be busy
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LINE_CAP + 8) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_codes(input logic [7:0] esc, input logic [7:0] brk, input logic [7:0] rec);
      csr_write(CSR_ESCAPE, esc);
      csr_write(CSR_BRACKET, brk);
      csr_write(CSR_RECALL, rec);
      escape_code  = esc;
      bracket_code = brk;
      recall_code  = rec;
   endtask

   task automatic random_traffic(input int target);
      int pick;
      int n;
      int k;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            // typed line, now and then long enough to fill the buffer
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 28) : $urandom_range(8);
            for (k = 0; k < n; k++) send_byte(typed_byte());
            send_byte(CH_LF);
         end else if (pick < 65) begin
            send_byte(escape_code);
            send_byte(bracket_code);
            send_byte(recall_code);
            n = $urandom_range(3);
            for (k = 0; k < n; k++) send_byte(typed_byte());
            if ($urandom_range(1)) send_byte(CH_LF);
         end else if (pick < 80) begin
            send_byte(escape_code);
            n = $urandom_range(3, 1);
            for (k = 0; k < n; k++)
               send_byte($urandom_range(3) == 0 ? bracket_code : 8'($urandom_range(255)));
         end else begin
            send_byte(8'($urandom_range(255)), $urandom_range(9) != 0);
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      calm                  = 1'b0;
      items_sent            = 0;
      csr_we                = 1'b0;
      csr_index             = CSR_ESCAPE;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.rx_byte      = '0;
      req_chan.reader_ready = 1'b0;
      escape_code           = ESCAPE_RESET;
      bracket_code          = BRACKET_RESET;
      recall_code           = RECALL_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed
      send_byte(8'h61);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CH_BS);
      send_byte(CH_CR);
      send_byte(CH_TAB);
      send_byte(8'h71, 1'b0);
      send_byte(CH_LF);
      send_byte(CH_BS);
      send_byte(escape_code);
      send_byte(bracket_code);
      send_byte(recall_code);
      send_byte(escape_code);
      send_byte(8'h7A);
      send_byte(bracket_code);
      send_byte(CH_LF);
      send_byte(CH_LF);
      send_byte(escape_code);
      send_byte(bracket_code);
      send_byte(recall_code);
      send_byte(escape_code);
      send_byte(CH_LF);
      send_byte(8'h80);
      send_byte(CH_LF);

      random_traffic(60);
      settle();
      random_traffic(100);
      settle();

      set_codes(8'h00, 8'hFF, CH_LF);
      random_traffic(150);
      settle();

      calm = 1'b1;
      set_codes(8'hFF, 8'h00, 8'h00);
      random_traffic(200);
      settle();
      calm = 1'b0;

      set_codes(CH_LF, CH_BS, CH_SP);
      random_traffic(230);
      settle();

      set_codes(ESCAPE_RESET, BRACKET_RESET, RECALL_RESET);
      random_traffic(280);
      settle();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
